// ===== rtl/bwlru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bwlru_pkg;

  localparam int unsigned TIME_W  = 40;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned EVC_W   = 6;

  localparam logic [SIZE_W-1:0] CAP_RESET = 32'd134217728;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic {
    CMP_KEY   = 1'b0,
    CMP_STAMP = 1'b1
  } cmp_mode_e;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [ROW_W-1:0]   row;
    logic [SIZE_W-1:0]  size;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    cmp_mode_e          mode;
    logic               have_best;
    logic [STAMP_W-1:0] best_stamp;
    logic [TIME_W-1:0]  key_time;
    logic [ROW_W-1:0]   key_row;
  } cmp_req_t;

endpackage

`default_nettype wire

// ===== rtl/bwlru_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bwlru_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic [bwlru_pkg::TIME_W-1:0]     time_ms;
  logic [bwlru_pkg::ROW_W-1:0]      row_px;
  logic [bwlru_pkg::SIZE_W-1:0]     item_bytes;

  modport source (output valid, output op, output time_ms, output row_px,
                  output item_bytes, input ready);
  modport sink (input valid, input op, input time_ms, input row_px,
                input item_bytes, output ready);
endinterface

interface bwlru_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [bwlru_pkg::SLOT_W-1:0]     slot;
  logic                             stored;
  logic [bwlru_pkg::EVC_W-1:0]      evicted_count;
  logic [bwlru_pkg::SIZE_W-1:0]     total_bytes;

  modport source (output valid, output hit, output slot, output stored,
                  output evicted_count, output total_bytes, input ready);
  modport sink (input valid, input hit, input slot, input stored,
                input evicted_count, input total_bytes, output ready);
endinterface

interface bwlru_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bwlru_pkg::SIZE_W-1:0]     budget;

  modport source (output valid, output budget, input ready);
  modport sink (input valid, input budget, output ready);
endinterface

`default_nettype wire

// ===== rtl/byte_weighted_lru_tile_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lookup: a key scan that reads one entry per cycle, then the result
// insert: key scan, then one stamp scan per eviction, a free-slot scan and a write;
//   the single ram read port sets the rate of the key and stamp scans
// clear, none and rejected insert: go straight to the result; one item at a time
// reset: entries invalid, total and use clock zero, capacity 134217728

module byte_weighted_lru_tile_cache #(
  parameter int ENTRIES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bwlru_req_if.sink        in_i,
  bwlru_rsp_if.source      out_o,
  bwlru_cfg_if.sink        cfg_i
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FIND  = 7'b0000010,
    ST_FIT   = 7'b0000100,
    ST_MIN   = 7'b0001000,
    ST_FREE  = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  bwlru_pkg::op_e                    op_q, op_d;
  logic [bwlru_pkg::TIME_W-1:0]      key_time_q, key_time_d;
  logic [bwlru_pkg::ROW_W-1:0]       key_row_q, key_row_d;
  logic [bwlru_pkg::SIZE_W-1:0]      bytes_q, bytes_d;
  logic [bwlru_pkg::SIZE_W-1:0]      cap_q, cap_d;
  logic [ENTRIES-1:0]                valid_q, valid_d;
  logic [bwlru_pkg::SIZE_W-1:0]      total_q, total_d;
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [bwlru_pkg::STAMP_W-1:0]     clock_q, clock_d;
  logic [IW:0]                       sc_q, sc_d;
  logic                              pend_q, pend_d;
  logic [IW-1:0]                     pidx_q, pidx_d;
  logic                              have_best_q, have_best_d;
  logic [bwlru_pkg::STAMP_W-1:0]     best_stamp_q, best_stamp_d;
  logic [IW-1:0]                     best_idx_q, best_idx_d;
  logic [bwlru_pkg::SIZE_W-1:0]      best_size_q, best_size_d;
  logic                              res_hit_q, res_hit_d;
  logic [IW-1:0]                     res_slot_q, res_slot_d;
  logic                              res_stored_q, res_stored_d;
  logic [bwlru_pkg::EVC_W-1:0]       res_evc_q, res_evc_d;
  logic                              out_vld_q, out_vld_d;
  logic                              o_hit_q, o_hit_d;
  logic [bwlru_pkg::SLOT_W-1:0]      o_slot_q, o_slot_d;
  logic                              o_stored_q, o_stored_d;
  logic [bwlru_pkg::EVC_W-1:0]       o_evc_q, o_evc_d;
  logic [bwlru_pkg::SIZE_W-1:0]      o_total_q, o_total_d;

  logic                              ram_we;
  logic [IW-1:0]                     ram_waddr;
  bwlru_pkg::entry_t                 ram_wdata;
  logic                              ram_re;
  bwlru_pkg::entry_t                 rd_data;

  bwlru_pkg::cmp_req_t               cmp_req;
  logic                              cmp_hit;

  logic                              issue;
  logic                              chk_valid;
  logic                              over;
  logic                              item_ok;
  logic [bwlru_pkg::STAMP_W-1:0]     clock_inc;

  bwlru_ram #(
    .WIDTH ($bits(bwlru_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (sc_q[IW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    cmp_req.mode       = (state_q == ST_MIN) ? bwlru_pkg::CMP_STAMP : bwlru_pkg::CMP_KEY;
    cmp_req.have_best  = have_best_q;
    cmp_req.best_stamp = best_stamp_q;
    cmp_req.key_time   = key_time_q;
    cmp_req.key_row    = key_row_q;
  end

  bwlru_cmp u_cmp (
    .req_i   (cmp_req),
    .entry_i (rd_data),
    .match_o (cmp_hit)
  );

  assign issue     = (sc_q < (IW + 1)'(ENTRIES));
  assign chk_valid = valid_q[pidx_q];
  assign over      = ({1'b0, total_q} + {1'b0, bytes_q}) > {1'b0, cap_q};
  assign item_ok   = (in_i.item_bytes != '0) && (in_i.item_bytes <= cap_q);
  assign clock_inc = clock_q + 48'd1;

  assign in_i.ready          = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = out_vld_q;
  assign out_o.hit           = o_hit_q;
  assign out_o.slot          = o_slot_q;
  assign out_o.stored        = o_stored_q;
  assign out_o.evicted_count = o_evc_q;
  assign out_o.total_bytes   = o_total_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_time_d   = key_time_q;
    key_row_d    = key_row_q;
    bytes_d      = bytes_q;
    cap_d        = cap_q;
    valid_d      = valid_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    clock_d      = clock_q;
    sc_d         = sc_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    have_best_d  = have_best_q;
    best_stamp_d = best_stamp_q;
    best_idx_d   = best_idx_q;
    best_size_d  = best_size_q;
    res_hit_d    = res_hit_q;
    res_slot_d   = res_slot_q;
    res_stored_d = res_stored_q;
    res_evc_d    = res_evc_q;
    out_vld_d    = out_vld_q;
    o_hit_d      = o_hit_q;
    o_slot_d     = o_slot_q;
    o_stored_d   = o_stored_q;
    o_evc_d      = o_evc_q;
    o_total_d    = o_total_q;
    ram_we       = 1'b0;
    ram_waddr    = pidx_q;
    ram_wdata    = rd_data;
    ram_re       = 1'b0;

    if (cfg_i.valid) begin
      cap_d = cfg_i.budget;
    end

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d         = bwlru_pkg::op_e'(in_i.op);
          key_time_d   = in_i.time_ms;
          key_row_d    = in_i.row_px;
          bytes_d      = in_i.item_bytes;
          res_hit_d    = 1'b0;
          res_slot_d   = '0;
          res_stored_d = 1'b0;
          res_evc_d    = '0;
          sc_d         = '0;
          pend_d       = 1'b0;
          unique case (bwlru_pkg::op_e'(in_i.op))
            bwlru_pkg::OP_LOOKUP: begin
              state_d = ST_FIND;
            end
            bwlru_pkg::OP_INSERT: begin
              state_d = item_ok ? ST_FIND : ST_DONE;
            end
            bwlru_pkg::OP_CLEAR: begin
              valid_d = '0;
              total_d = '0;
              cnt_d   = '0;
              state_d = ST_DONE;
            end
            bwlru_pkg::OP_NONE: begin
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_FIND: begin
        ram_re = issue;
        if (issue) begin
          sc_d = sc_q + (IW + 1)'(1);
        end
        pend_d = issue;
        pidx_d = sc_q[IW-1:0];
        if (pend_q && chk_valid && cmp_hit) begin
          if (op_q == bwlru_pkg::OP_LOOKUP) begin
            ram_we          = 1'b1;
            ram_waddr       = pidx_q;
            ram_wdata       = rd_data;
            ram_wdata.stamp = clock_inc;
            clock_d         = clock_inc;
            res_hit_d       = 1'b1;
            res_slot_d      = pidx_q;
            state_d         = ST_DONE;
          end else begin
            valid_d[pidx_q] = 1'b0;
            total_d         = total_q - rd_data.size;
            cnt_d           = cnt_q - CW'(1);
            state_d         = ST_FIT;
          end
        end else if (!issue && !pend_q) begin
          state_d = (op_q == bwlru_pkg::OP_LOOKUP) ? ST_DONE : ST_FIT;
        end
      end

      ST_FIT: begin
        sc_d   = '0;
        pend_d = 1'b0;
        if (((cnt_q != '0) && over) || (cnt_q == CW'(ENTRIES))) begin
          have_best_d = 1'b0;
          state_d     = ST_MIN;
        end else begin
          state_d = ST_FREE;
        end
      end

      ST_MIN: begin
        ram_re = issue;
        if (issue) begin
          sc_d = sc_q + (IW + 1)'(1);
        end
        pend_d = issue;
        pidx_d = sc_q[IW-1:0];
        if (pend_q && chk_valid && cmp_hit) begin
          have_best_d  = 1'b1;
          best_stamp_d = rd_data.stamp;
          best_idx_d   = pidx_q;
          best_size_d  = rd_data.size;
        end
        if (!issue && !pend_q) begin
          valid_d[best_idx_q] = 1'b0;
          total_d             = total_q - best_size_q;
          cnt_d               = cnt_q - CW'(1);
          res_evc_d           = res_evc_q + 6'd1;
          state_d             = ST_FIT;
        end
      end

      ST_FREE: begin
        if (!valid_q[sc_q[IW-1:0]]) begin
          res_slot_d = sc_q[IW-1:0];
          state_d    = ST_WRITE;
        end else begin
          sc_d = sc_q + (IW + 1)'(1);
        end
      end

      ST_WRITE: begin
        ram_we                = 1'b1;
        ram_waddr             = res_slot_q;
        ram_wdata.time_ms     = key_time_q;
        ram_wdata.row         = key_row_q;
        ram_wdata.size        = bytes_q;
        ram_wdata.stamp       = clock_inc;
        clock_d               = clock_inc;
        valid_d[res_slot_q]   = 1'b1;
        total_d               = total_q + bytes_q;
        cnt_d                 = cnt_q + CW'(1);
        res_stored_d          = 1'b1;
        state_d               = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          o_hit_d    = res_hit_q;
          o_slot_d   = bwlru_pkg::SLOT_W'(res_slot_q);
          o_stored_d = res_stored_q;
          o_evc_d    = res_evc_q;
          o_total_d  = total_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= bwlru_pkg::CAP_RESET;
      valid_q     <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      clock_q     <= '0;
      sc_q        <= '0;
      pend_q      <= 1'b0;
      have_best_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      valid_q     <= valid_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      clock_q     <= clock_d;
      sc_q        <= sc_d;
      pend_q      <= pend_d;
      have_best_q <= have_best_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_time_q   <= key_time_d;
    key_row_q    <= key_row_d;
    bytes_q      <= bytes_d;
    pidx_q       <= pidx_d;
    best_stamp_q <= best_stamp_d;
    best_idx_q   <= best_idx_d;
    best_size_q  <= best_size_d;
    res_hit_q    <= res_hit_d;
    res_slot_q   <= res_slot_d;
    res_stored_q <= res_stored_d;
    res_evc_q    <= res_evc_d;
    o_hit_q      <= o_hit_d;
    o_slot_q     <= o_slot_d;
    o_stored_q   <= o_stored_d;
    o_evc_q      <= o_evc_d;
    o_total_q    <= o_total_d;
  end

endmodule

`default_nettype wire

// ===== rtl/bwlru_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bwlru_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwlru_cmp (
  input  bwlru_pkg::cmp_req_t req_i,
  input  bwlru_pkg::entry_t   entry_i,
  output logic                match_o
);

  always_comb begin
    unique case (req_i.mode)
      bwlru_pkg::CMP_KEY: begin
        match_o = (entry_i.time_ms == req_i.key_time) && (entry_i.row == req_i.key_row);
      end
      bwlru_pkg::CMP_STAMP: begin
        match_o = !req_i.have_best || (entry_i.stamp < req_i.best_stamp);
      end
      default: begin
        match_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bwlru_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwlru_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        hit_i,
  input logic [4:0]  slot_i,
  input logic        stored_i,
  input logic [5:0]  evicted_count_i,
  input logic [31:0] total_bytes_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(slot_i) && $stable(total_bytes_i))
    else $error("stalled result changed");

  // busy after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // a result is never both a hit and a store
  a_hit_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(hit_i && stored_i))
    else $error("hit and stored together");

  // lookup hits report no evictions
  a_hit_evc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> evicted_count_i == 6'd0)
    else $error("eviction reported on lookup hit");

  // no slot without hit or store
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i && !stored_i |-> slot_i == 5'd0)
    else $error("slot reported without hit or store");

endmodule

bind byte_weighted_lru_tile_cache bwlru_checker u_bwlru_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .hit_i           (out_o.hit),
  .slot_i          (out_o.slot),
  .stored_i        (out_o.stored),
  .evicted_count_i (out_o.evicted_count),
  .total_bytes_i   (out_o.total_bytes)
);

`default_nettype wire
